@@ hdl/mcg_pkg.sv @@
package mcg_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 11;
  localparam int OUT_BITS    = 14;
  // signed step coordinates, room for y dropping below zero on the last step
  localparam int STEP_BITS   = RADIUS_BITS + 2;
  localparam int DEC_BITS    = RADIUS_BITS + 5;
  localparam int CALC_MIN    = ((COORD_BITS > STEP_BITS) ? COORD_BITS : STEP_BITS) + 2;
  localparam int CALC_BITS   = (CALC_MIN > OUT_BITS) ? CALC_MIN : OUT_BITS;

  localparam int IDX_BITS    = 3;
  localparam logic [IDX_BITS-1:0] LAST_POINT = IDX_BITS'(7);
  localparam logic [IDX_BITS-1:0] LAST_SPAN  = IDX_BITS'(3);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef logic        [COORD_BITS-1:0] coord_t;
  typedef logic        [RADIUS_BITS-1:0] radius_t;
  typedef logic signed [STEP_BITS-1:0]  step_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic signed [OUT_BITS-1:0]   pix_t;
  typedef logic signed [CALC_BITS-1:0]  calc_t;

  // one octant set waiting to be emitted
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    step_t  x;
    step_t  y;
    logic   fill;
    logic   done;
  } step_rec_t;

  typedef struct packed {
    logic active;
    logic filling;
  } front_stat_t;

endpackage

@@ hdl/mcg_if.sv @@
interface mcg_in_if;
  import mcg_pkg::*;

  logic    valid;
  logic    ready;
  logic    cmd;
  coord_t  center_x;
  coord_t  center_y;
  radius_t radius;
  logic    fill_mode;

  modport source (output valid, cmd, center_x, center_y, radius, fill_mode, input ready);
  modport sink   (input valid, cmd, center_x, center_y, radius, fill_mode, output ready);
endinterface

interface mcg_out_if;
  import mcg_pkg::*;

  logic valid;
  logic ready;
  pix_t start_x;
  pix_t start_y;
  pix_t end_x;
  pix_t end_y;
  logic is_span;
  logic last_of_step;
  logic circle_done;

  modport source (output valid, start_x, start_y, end_x, end_y, is_span, last_of_step,
                  circle_done, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, is_span, last_of_step,
                  circle_done, output ready);
endinterface

@@ hdl/mcg_front.sv @@
module mcg_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mcg_in_if.sink               in_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output mcg_pkg::step_rec_t   q_rec_o,
  output mcg_pkg::front_stat_t stat_o
);
  import mcg_pkg::*;

  coord_t cx_q, cx_d;
  coord_t cy_q, cy_d;
  logic   fill_q, fill_d;
  logic   act_q, act_d;
  step_t  x_q, x_d;
  step_t  y_q, y_d;
  dec_t   d_q, d_d;

  logic   fire;
  step_t  x_nx;
  step_t  y_nx;
  dec_t   x_ext;
  dec_t   y_ext;
  logic   more;

  assign in_i.ready = !q_full_i;
  assign fire       = in_i.valid && in_i.ready;

  assign x_ext = DEC_BITS'(x_q);
  assign y_ext = DEC_BITS'(y_q);
  assign x_nx  = x_q + STEP_BITS'(1);
  assign y_nx  = (d_q <= 0) ? y_q : y_q - STEP_BITS'(1);
  assign more  = x_nx < y_nx;

  always_comb begin
    cx_d   = cx_q;
    cy_d   = cy_q;
    fill_d = fill_q;
    act_d  = act_q;
    x_d    = x_q;
    y_d    = y_q;
    d_d    = d_q;
    q_push_o = 1'b0;
    if (fire && in_i.cmd == CMD_START) begin
      cx_d   = in_i.center_x;
      cy_d   = in_i.center_y;
      fill_d = in_i.fill_mode;
      act_d  = 1'b1;
      x_d    = '0;
      y_d    = $signed({2'b00, in_i.radius});
      d_d    = DEC_BITS'(3) - (DEC_BITS'(in_i.radius) <<< 1);
    end else if (fire && act_q) begin
      q_push_o = 1'b1;
      if (d_q <= 0) begin
        d_d = d_q + (x_ext <<< 2) + DEC_BITS'(6);
      end else begin
        d_d = d_q + ((x_ext - y_ext) <<< 2) + DEC_BITS'(10);
      end
      x_d   = x_nx;
      y_d   = y_nx;
      act_d = more;
    end
  end

  assign q_rec_o.cx   = cx_q;
  assign q_rec_o.cy   = cy_q;
  assign q_rec_o.x    = x_q;
  assign q_rec_o.y    = y_q;
  assign q_rec_o.fill = fill_q;
  assign q_rec_o.done = !more;

  assign stat_o.active  = act_q;
  assign stat_o.filling = fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= '0;
      cy_q   <= '0;
      fill_q <= 1'b0;
      act_q  <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      d_q    <= '0;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      fill_q <= fill_d;
      act_q  <= act_d;
      x_q    <= x_d;
      y_q    <= y_d;
      d_q    <= d_d;
    end
  end

endmodule

@@ hdl/mcg_queue.sv @@
module mcg_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mcg_pkg::step_rec_t rec_i,
  output logic               full_o,
  input  logic               pop_i,
  output mcg_pkg::step_rec_t head_o,
  output logic               empty_o
);
  import mcg_pkg::*;

  step_rec_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]      wr_q, wr_d;
  logic [QPTR_BITS-1:0]      rd_q, rd_d;
  logic [QPTR_BITS:0]        cnt_q, cnt_d;

  assign full_o  = cnt_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + QPTR_BITS'(1) : wr_q;
    rd_d  = pop_i  ? rd_q + QPTR_BITS'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QPTR_BITS+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hdl/mcg_back.sv @@
module mcg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcg_pkg::step_rec_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  mcg_out_if.source          out_o
);
  import mcg_pkg::*;

  logic [IDX_BITS-1:0] idx_q, idx_d;
  logic                ovld_q, ovld_d;
  pix_t                sx_q, sy_q, ex_q, ey_q;
  logic                span_q, last_q, done_q;

  logic                load;
  logic                is_last;
  logic                swap, neg_col, neg_row;
  calc_t               col_mag, row_mag, off_col, off_row;
  calc_t               cx_ext, cy_ext;
  calc_t               sc, sr, er;

  assign load    = !empty_i && (!ovld_q || out_o.ready);
  assign is_last = idx_q == (head_i.fill ? LAST_SPAN : LAST_POINT);
  assign pop_o   = load && is_last;

  // octant pattern: outline walks sign bits then swap, fill pairs mirrored spans
  always_comb begin
    if (head_i.fill) begin
      swap    = idx_q[0];
      neg_col = idx_q[1];
      neg_row = idx_q[1];
    end else begin
      swap    = idx_q[2];
      neg_col = idx_q[0];
      neg_row = idx_q[1];
    end
  end

  assign col_mag = swap ? CALC_BITS'(head_i.y) : CALC_BITS'(head_i.x);
  assign row_mag = swap ? CALC_BITS'(head_i.x) : CALC_BITS'(head_i.y);
  assign off_col = neg_col ? -col_mag : col_mag;
  assign off_row = neg_row ? -row_mag : row_mag;
  assign cx_ext  = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, head_i.cx});
  assign cy_ext  = $signed({{(CALC_BITS-COORD_BITS){1'b0}}, head_i.cy});
  assign sc      = cx_ext + off_col;
  assign sr      = cy_ext + off_row;
  assign er      = head_i.fill ? cy_ext - off_row : sr;

  always_comb begin
    idx_d  = idx_q;
    ovld_d = ovld_q;
    if (out_o.ready) begin
      ovld_d = 1'b0;
    end
    if (load) begin
      ovld_d = 1'b1;
      idx_d  = is_last ? '0 : idx_q + IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sx_q   <= sc[OUT_BITS-1:0];
      sy_q   <= sr[OUT_BITS-1:0];
      ex_q   <= sc[OUT_BITS-1:0];
      ey_q   <= er[OUT_BITS-1:0];
      span_q <= head_i.fill;
      last_q <= is_last;
      done_q <= is_last && head_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      ovld_q <= ovld_d;
    end
  end

  assign out_o.valid        = ovld_q;
  assign out_o.start_x      = sx_q;
  assign out_o.start_y      = sy_q;
  assign out_o.end_x        = ex_q;
  assign out_o.end_y        = ey_q;
  assign out_o.is_span      = span_q;
  assign out_o.last_of_step = last_q;
  assign out_o.circle_done  = done_q;

endmodule

@@ hdl/midpoint_circle_generator.sv @@
// a step item goes into the step queue, then the back end loads its first result into the
// output register, held back by queued steps or a stalled sink; start items emit nothing;
// a step gives 8 results in outline mode, 4 in fill mode, one per cycle while sink is ready
// the two-entry step queue lets the front take items while the back drains earlier steps
// reset (async, active low): no circle active, step state zero, queue and output empty
module midpoint_circle_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcg_in_if.sink     in_i,
  mcg_out_if.source  out_o
);
  import mcg_pkg::*;

  // front to queue
  logic        q_push;
  logic        q_full;
  step_rec_t   q_rec;
  front_stat_t stat;

  // queue to back
  logic        q_pop;
  logic        q_empty;
  step_rec_t   q_head;

  // front: holds centre, x, y and decision value; a step while active
  // snapshots the octant set into the queue and advances the midpoint state
  mcg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_rec_o  (q_rec),
    .stat_o   (stat)
  );

  // short queue of pending octant sets
  mcg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (q_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // back: walks the points or spans of the head entry, one per cycle while the sink is ready
  mcg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (q_head),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  // front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("step queue overflow");

  // circle end is only flagged on the closing item of a step
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.circle_done) |-> out_o.last_of_step)
    else $error("circle_done without last_of_step");

  // a start item always leaves a circle in progress
  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.cmd == CMD_START) |=> stat.active)
    else $error("start did not activate circle");

  // single points carry equal endpoints
  a_point_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.is_span) |->
      (out_o.start_x == out_o.end_x && out_o.start_y == out_o.end_y))
    else $error("point with differing endpoints");

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcg_pkg::*;

  localparam int RANDOM_ITEMS = 420;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = 300;
  localparam int SHOW_MAX     = 10;

  // one emitted point or fill span, laid out like the output channel
  typedef struct packed {
    pix_t sx;
    pix_t sy;
    pix_t ex;
    pix_t ey;
    logic span;
    logic last;
    logic done;
  } pixel_rec_t;

  logic clk;
  logic rst_n;

  mcg_in_if  in_bus ();
  mcg_out_if out_bus ();

  midpoint_circle_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // rasteriser state as seen from the item stream
  coord_t ctr_col;
  coord_t ctr_row;
  logic   filling;
  int     cur_x;
  int     cur_y;
  int     decision;
  logic   circ_active;

  pixel_rec_t pending_pixels[$];
  int         fail_count;
  int         cycle_count = 0;

  // idle-free stretches for the sender and the result side
  logic src_quiet;
  logic sink_quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop if the run hangs on a handshake or a missing result
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic pixel_rec_t pix_pair(input int sx, input int sy, input int ex,
                                          input int ey, input logic span);
    pixel_rec_t p;
    p.sx   = pix_t'(sx);
    p.sy   = pix_t'(sy);
    p.ex   = pix_t'(ex);
    p.ey   = pix_t'(ey);
    p.span = span;
    p.last = 1'b0;
    p.done = 1'b0;
    return p;
  endfunction

  // apply one accepted item to the circle state and queue the octant set it emits
  task automatic plot_octants(input cmd_e op, input coord_t cx_in, input coord_t cy_in,
                              input radius_t r_in, input logic fill_in);
    pixel_rec_t octs[8];
    int         cx;
    int         cy;
    int         x;
    int         y;
    int         n;
    if (op == CMD_START) begin
      // start: load the circle, emits nothing, abandons any circle in progress
      ctr_col     = cx_in;
      ctr_row     = cy_in;
      filling     = fill_in;
      cur_x       = 0;
      cur_y       = int'(r_in);
      decision    = 3 - 2 * int'(r_in);
      circ_active = 1'b1;
      return;
    end
    // step with no circle in progress is dropped silently
    if (!circ_active) return;
    cx = int'(ctr_col);
    cy = int'(ctr_row);
    x  = cur_x;
    y  = cur_y;
    if (filling) begin
      octs[0] = pix_pair(cx + x, cy + y, cx + x, cy - y, 1'b1);
      octs[1] = pix_pair(cx + y, cy + x, cx + y, cy - x, 1'b1);
      octs[2] = pix_pair(cx - x, cy - y, cx - x, cy + y, 1'b1);
      octs[3] = pix_pair(cx - y, cy - x, cx - y, cy + x, 1'b1);
      n = 4;
    end else begin
      // duplicates on the axes are kept, as the block emits them
      octs[0] = pix_pair(cx + x, cy + y, cx + x, cy + y, 1'b0);
      octs[1] = pix_pair(cx - x, cy + y, cx - x, cy + y, 1'b0);
      octs[2] = pix_pair(cx + x, cy - y, cx + x, cy - y, 1'b0);
      octs[3] = pix_pair(cx - x, cy - y, cx - x, cy - y, 1'b0);
      octs[4] = pix_pair(cx + y, cy + x, cx + y, cy + x, 1'b0);
      octs[5] = pix_pair(cx - y, cy + x, cx - y, cy + x, 1'b0);
      octs[6] = pix_pair(cx + y, cy - x, cx + y, cy - x, 1'b0);
      octs[7] = pix_pair(cx - y, cy - x, cx - y, cy - x, 1'b0);
      n = 8;
    end
    // midpoint decision update
    if (decision <= 0) begin
      decision = decision + 4 * x + 6;
    end else begin
      decision = decision + 4 * (x - y) + 10;
      y = y - 1;
    end
    x = x + 1;
    cur_x = x;
    cur_y = y;
    octs[n-1].last = 1'b1;
    if (!(x < y)) begin
      circ_active    = 1'b0;
      octs[n-1].done = 1'b1;
    end
    for (int i = 0; i < n; i++) pending_pixels.push_back(octs[i]);
  endtask

  // called at a rising edge; returns at the edge where the item was accepted
  task automatic send_item(input cmd_e op, input coord_t cx, input coord_t cy,
                           input radius_t r, input logic fill);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.cmd       <= op;
    in_bus.center_x  <= cx;
    in_bus.center_y  <= cy;
    in_bus.radius    <= r;
    in_bus.fill_mode <= fill;
    do @(posedge clk); while (!in_bus.ready);
    plot_octants(op, cx, cy, r, fill);
  endtask

  // step items carry junk in the unused fields
  task automatic step_once();
    send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom),
              1'($urandom));
  endtask

  // hold off the sender until every queued result has come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic check_pixel();
    pixel_rec_t got;
    pixel_rec_t want;
    got.sx   = out_bus.start_x;
    got.sy   = out_bus.start_y;
    got.ex   = out_bus.end_x;
    got.ey   = out_bus.end_y;
    got.span = out_bus.is_span;
    got.last = out_bus.last_of_step;
    got.done = out_bus.circle_done;
    if (pending_pixels.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOW_MAX)
        $display("unexpected result (%0d,%0d)-(%0d,%0d) span=%0b last=%0b done=%0b",
                 got.sx, got.sy, got.ex, got.ey, got.span, got.last, got.done);
    end else begin
      want = pending_pixels.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= SHOW_MAX) begin
          $display("mismatch: exp (%0d,%0d)-(%0d,%0d) span=%0b last=%0b done=%0b",
                   want.sx, want.sy, want.ex, want.ey, want.span, want.last, want.done);
          $display("          got (%0d,%0d)-(%0d,%0d) span=%0b last=%0b done=%0b",
                   got.sx, got.sy, got.ex, got.ey, got.span, got.last, got.done);
        end
      end
    end
  endtask

  // result side: random stall before each item, then hold ready until it arrives
  initial begin : result_monitor
    int hold;
    out_bus.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = sink_quiet ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      check_pixel();
    end
  end

  // steps before any start must produce nothing
  task automatic test_idle_steps();
    step_once();
    step_once();
  endtask

  // zero radius: centre eight times (or four degenerate spans), finished at once
  task automatic test_zero_radius();
    send_item(CMD_START, coord_t'(0), coord_t'(0), radius_t'(0), 1'b0);
    step_once();
    send_item(CMD_START, coord_t'(4095), coord_t'(4095), radius_t'(0), 1'b1);
    step_once();
    step_once();
  endtask

  // small circles run to completion in both modes
  task automatic test_full_circles();
    send_item(CMD_START, coord_t'(100), coord_t'(200), radius_t'(5), 1'b0);
    while (circ_active) step_once();
    send_item(CMD_START, coord_t'(3000), coord_t'(17), radius_t'(3), 1'b1);
    while (circ_active) step_once();
  endtask

  // extreme centres and radius, negative columns and rows, restart mid-circle
  task automatic test_wide_circles();
    send_item(CMD_START, coord_t'(4095), coord_t'(0), radius_t'(2047), 1'b1);
    repeat (3) step_once();
    send_item(CMD_START, coord_t'(0), coord_t'(4095), radius_t'(2047), 1'b0);
    repeat (2) step_once();
    send_item(CMD_START, coord_t'(2048), coord_t'(2048), radius_t'(10), 1'b0);
    repeat (2) step_once();
    send_item(CMD_START, coord_t'(1), coord_t'(1), radius_t'(1), 1'b1);
    while (circ_active) step_once();
  endtask

  // mostly complete circles with random content, some aborted by a new start,
  // some trailing steps that hit an idle block
  task automatic test_random_circles();
    int      live;
    int      circle_no;
    int      abort_at;
    int      steps;
    int      pick;
    radius_t r;
    live      = 0;
    circle_no = 0;
    while (live < RANDOM_ITEMS) begin
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 8) r = radius_t'($urandom_range(0, 24));
      else if (pick == 8) r = radius_t'($urandom_range(25, 200));
      else r = radius_t'($urandom_range(0, 2047));
      // big circles would take too long, so cut them short
      abort_at = (r > 200 || $urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : -1;
      send_item(CMD_START, coord_t'($urandom), coord_t'($urandom), r, 1'($urandom));
      live++;
      steps = 0;
      while (circ_active && steps != abort_at) begin
        step_once();
        live++;
        steps++;
      end
      if (!circ_active && $urandom_range(0, 4) == 0) step_once();
      if (circle_no == 12) wait_drained();
      circle_no++;
    end
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.cmd       = CMD_START;
    in_bus.center_x  = '0;
    in_bus.center_y  = '0;
    in_bus.radius    = '0;
    in_bus.fill_mode = 1'b0;
    src_quiet        = 1'b0;
    sink_quiet       = 1'b0;
    fail_count       = 0;
    ctr_col          = '0;
    ctr_row          = '0;
    filling          = 1'b0;
    cur_x            = 0;
    cur_y            = 0;
    decision         = 0;
    circ_active      = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_steps();
    test_zero_radius();
    test_full_circles();
    test_wide_circles();
    wait_drained();
    test_random_circles();

    // let stray results show up after the last expected one
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mcg_pkg.sv
hdl/mcg_if.sv
hdl/mcg_front.sv
hdl/mcg_queue.sv
hdl/mcg_back.sv
hdl/midpoint_circle_generator.sv
verif/tb_top.sv
